/* design/srd_pkg.sv */
package srd_pkg;

  localparam int unsigned MARK_W  = 8;
  localparam int unsigned SUBJ_W  = 5;
  localparam int unsigned TOTAL_W = 12;
  localparam int unsigned NUM_W   = 6;
  localparam int unsigned POS_W   = 7;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // One stored record: total and arrival number minus one.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [NUM_W-1:0]   num;
  } rec_t;

  // Insertion wave travelling down the chain; slot is the free cell it fills.
  // moved marks a record already pushed out of its cell: it must take every
  // following cell so that it stays ahead of records that came after it.
  typedef struct packed {
    logic             valid;
    logic             moved;
    logic [NUM_W-1:0] slot;
    rec_t             rec;
  } wave_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SETTLE,
    ST_DRAIN
  } state_e;

endpackage

/* design/srd_mark_if.sv */
interface srd_mark_if;
  import srd_pkg::*;

  logic              valid;
  logic              ready;
  logic [MARK_W-1:0] mark;
  logic              last_mark;

  modport source (output valid, output mark, output last_mark, input ready);
  modport sink (input valid, input mark, input last_mark, output ready);
endinterface

/* design/srd_result_if.sv */
interface srd_result_if;
  import srd_pkg::*;

  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   position;
  logic [TOTAL_W-1:0] total;
  logic [POS_W-1:0]   original_number;
  logic               overflowed;
  logic               last;

  modport source (output valid, output position, output total, output original_number,
                  output overflowed, output last, input ready);
  modport sink (input valid, input position, input total, input original_number,
                input overflowed, input last, output ready);
endinterface

/* design/srd_accum.sv */
module srd_accum #(
  parameter int unsigned MAX_RECORDS  = 64,
  parameter int unsigned MAX_SUBJECTS = 16,
  parameter int unsigned MARK_BITS    = 8,
  localparam int unsigned CNT_W       = $clog2(MAX_RECORDS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [srd_pkg::MARK_W-1:0] mark_i,
  input  logic                  last_mark_i,
  input  logic [srd_pkg::SUBJ_W-1:0] subjects_i,
  input  logic                  clear_i,
  output srd_pkg::wave_t        wave_o,
  output logic [CNT_W-1:0]      count_o,
  output logic                  dropped_o
);
  import srd_pkg::*;

  localparam logic [MARK_W-1:0] MARK_MASK =
      (MARK_BITS >= MARK_W) ? {MARK_W{1'b1}} : MARK_W'((1 << MARK_BITS) - 1);
  localparam logic [SUBJ_W-1:0] SUBJ_MAX = SUBJ_W'(MAX_SUBJECTS);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_RECORDS);

  logic [TOTAL_W-1:0] sum_q, sum_d;
  logic [SUBJ_W-1:0]  mcnt_q, mcnt_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               dropped_q, dropped_d;
  wave_t              wave_q, wave_d;

  logic [TOTAL_W:0]   sum_ext;
  logic [TOTAL_W-1:0] sum_sat;
  logic [SUBJ_W-1:0]  subj_eff;
  logic [SUBJ_W-1:0]  mcnt_inc;
  logic               close;
  logic               full;

  always_comb begin
    sum_ext  = {1'b0, sum_q} + (TOTAL_W + 1)'(mark_i & MARK_MASK);
    sum_sat  = sum_ext[TOTAL_W] ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
    subj_eff = subjects_i;
    if (subj_eff == '0) begin
      subj_eff = SUBJ_W'(1);
    end
    if (subj_eff > SUBJ_MAX) begin
      subj_eff = SUBJ_MAX;
    end
    mcnt_inc = mcnt_q + SUBJ_W'(1);
    close    = fire_i && ((mcnt_inc >= subj_eff) || last_mark_i);
    full     = (count_q >= CNT_FULL);
  end

  always_comb begin
    sum_d        = sum_q;
    mcnt_d       = mcnt_q;
    count_d      = count_q;
    dropped_d    = dropped_q;
    wave_d       = wave_q;
    wave_d.valid = 1'b0;
    if (clear_i) begin
      count_d   = '0;
      dropped_d = 1'b0;
    end else if (fire_i) begin
      if (close) begin
        sum_d  = '0;
        mcnt_d = '0;
        if (full) begin
          dropped_d = 1'b1;
        end else begin
          wave_d.valid     = 1'b1;
          wave_d.moved     = 1'b0;
          wave_d.slot      = NUM_W'(count_q);
          wave_d.rec.total = sum_sat;
          wave_d.rec.num   = NUM_W'(count_q);
          count_d          = count_q + CNT_W'(1);
        end
      end else begin
        sum_d  = sum_sat;
        mcnt_d = mcnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      mcnt_q    <= '0;
      count_q   <= '0;
      dropped_q <= 1'b0;
      wave_q    <= '0;
    end else begin
      sum_q     <= sum_d;
      mcnt_q    <= mcnt_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      wave_q    <= wave_d;
    end
  end

  assign wave_o    = wave_q;
  assign count_o   = count_q;
  assign dropped_o = dropped_q;

endmodule

/* design/srd_cell.sv */
module srd_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srd_pkg::wave_t wave_i,
  input  logic           shift_i,
  input  srd_pkg::rec_t  below_i,
  output srd_pkg::rec_t  held_o,
  output srd_pkg::wave_t wave_o
);
  import srd_pkg::*;

  localparam logic [NUM_W-1:0] MY_SLOT = NUM_W'(CELL_IDX);

  rec_t  held_q, held_d;
  wave_t wave_q, wave_d;
  logic  land;
  logic  win;

  always_comb begin
    land   = wave_i.valid && (wave_i.slot == MY_SLOT);
    win    = wave_i.valid && !land &&
             (wave_i.moved || (wave_i.rec.total > held_q.total));
    held_d = held_q;
    if (shift_i) begin
      held_d = below_i;
    end else if (land || win) begin
      held_d = wave_i.rec;
    end
    // Pass the loser on; a landed wave ends here.
    wave_d       = wave_i;
    wave_d.valid = wave_i.valid && !land;
    if (win) begin
      wave_d.rec   = held_q;
      wave_d.moved = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  assign held_o = held_q;
  assign wave_o = wave_q;

endmodule

/* design/sum_and_rank_descending.sv */
// Channel   Direction  Beat contents
// in_i      sink       mark, last_mark
// out_o     source     position, total, original_number, overflowed, last
// cfg       write      cfg_data_i = subjects_per_student, taken when cfg_we_i is high
//
// Filling: one mark beat per cycle. A mark that closes a record launches an insertion
// wave into the cell chain; a new wave can enter while earlier waves are still travelling.
// After last_mark the chain settles while the deepest wave lands (one cell per cycle), then
// one result beat per cycle while out_o.ready is high; in_i is held off until the last
// result beat of the listing has gone.
// Reset leaves the cells undefined; the fill count tells which ones are occupied.
// A stall on out_o holds the head cell and the position counter.
module sum_and_rank_descending #(
  parameter int unsigned MAX_RECORDS  = 64,
  parameter int unsigned MAX_SUBJECTS = 16,
  parameter int unsigned MARK_BITS    = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [srd_pkg::SUBJ_W-1:0] cfg_data_i,
  srd_mark_if.sink                   in_i,
  srd_result_if.source               out_o
);
  import srd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int unsigned SET_W = $clog2(MAX_RECORDS);
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(MAX_RECORDS - 1);

  logic [SUBJ_W-1:0] subj_q;
  state_e            state_q, state_d;
  logic [SET_W-1:0]  settle_q, settle_d;
  logic [POS_W-1:0]  pos_q, pos_d;

  logic              in_fire;
  logic              out_fire;
  logic              list_done;
  logic              in_ready;
  logic              out_valid;

  wave_t             wave_head;
  logic [CNT_W-1:0]  count;
  logic              dropped;

  wave_t             wave_chain [MAX_RECORDS+1];
  rec_t              held       [MAX_RECORDS+1];

  // Subjects per record; the user must write it only while idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subj_q <= SUBJ_W'(1);
    end else if (cfg_we_i) begin
      subj_q <= cfg_data_i;
    end
  end

  assign in_fire   = in_i.valid && in_ready;
  assign out_fire  = out_valid && out_o.ready;
  assign list_done = out_fire && (pos_q == POS_W'(count));

  srd_accum #(
    .MAX_RECORDS (MAX_RECORDS),
    .MAX_SUBJECTS(MAX_SUBJECTS),
    .MARK_BITS   (MARK_BITS)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .mark_i     (in_i.mark),
    .last_mark_i(in_i.last_mark),
    .subjects_i (subj_q),
    .clear_i    (list_done),
    .wave_o     (wave_head),
    .count_o    (count),
    .dropped_o  (dropped)
  );

  // Cell k holds rank k+1. During the listing every accepted result beat moves the
  // whole row one cell toward the head; the tail takes a don't-care record.
  assign wave_chain[0]     = wave_head;
  assign held[MAX_RECORDS] = '0;

  for (genvar k = 0; k < MAX_RECORDS; k++) begin : g_cell
    srd_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wave_i (wave_chain[k]),
      .shift_i(out_fire),
      .below_i(held[k+1]),
      .held_o (held[k]),
      .wave_o (wave_chain[k+1])
    );
  end

  // Next state: fill until last_mark, let the deepest wave land, then list.
  always_comb begin
    state_d  = state_q;
    settle_d = settle_q;
    pos_d    = pos_q;
    case (state_q)
      ST_FILL: begin
        settle_d = '0;
        if (in_fire && in_i.last_mark) begin
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        settle_d = settle_q + SET_W'(1);
        if (settle_q == SET_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (list_done) begin
          state_d = ST_FILL;
          pos_d   = POS_W'(1);
        end else if (out_fire) begin
          pos_d = pos_q + POS_W'(1);
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  // Handshake outputs from the state alone.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_q)
      ST_FILL:   in_ready  = 1'b1;
      ST_SETTLE: in_ready  = 1'b0;
      ST_DRAIN:  out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_FILL;
      settle_q <= '0;
      pos_q    <= POS_W'(1);
    end else begin
      state_q  <= state_d;
      settle_q <= settle_d;
      pos_q    <= pos_d;
    end
  end

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_valid;
  assign out_o.position        = pos_q;
  assign out_o.total           = held[0].total;
  assign out_o.original_number = POS_W'(held[0].num) + POS_W'(1);
  assign out_o.overflowed      = dropped;
  assign out_o.last            = (pos_q == POS_W'(count));

endmodule

/* design/srd_checker.sv */
module srd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_last,
  input logic [srd_pkg::POS_W-1:0] out_position
);
  import srd_pkg::*;

  // No mark is taken while a listing is out.
  a_no_in_during_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input ready during listing");

  a_first_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !$past(out_valid)) |-> (out_position == POS_W'(1)))
    else $error("listing does not start at rank one");

  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && (out_position == $past(out_position) + POS_W'(1))))
    else $error("rank did not advance by one");

  a_end_of_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("result after final beat");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_position)))
    else $error("stalled result beat changed");

endmodule

bind sum_and_rank_descending srd_checker u_srd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_last    (out_o.last),
  .out_position(out_o.position)
);
